// ===== rtl/core/nhd_pkg.sv =====
// Shared widths, register indexes, codes and reset values of the neighbour and hop-distance block.
package nhd_pkg;

    // Payload widths.
    localparam int CMD_W    = 1;
    localparam int NODE_W   = 18;
    localparam int PORT_W   = 4;
    localparam int STATUS_W = 2;
    localparam int KIND_W   = 2;
    localparam int HOP_W    = 8;

    // Register widths.
    localparam int TOPO_W     = 3;
    localparam int DIMS_W     = 2;
    localparam int SIZE_W     = 7;
    localparam int PCNT_W     = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 7;

    // Default limits for the top level parameters.
    localparam int DEF_MAX_DIMENSIONS = 3;
    localparam int DEF_MAX_AXIS_SIZE  = 64;
    localparam int DEF_MAX_PORTS      = 16;

    // Register indexes on the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TOPOLOGY   = 3'd0,
        CFG_DIMENSIONS = 3'd1,
        CFG_SIZE_AXIS0 = 3'd2,
        CFG_SIZE_AXIS1 = 3'd3,
        CFG_SIZE_AXIS2 = 3'd4,
        CFG_PORT_COUNT = 3'd5
    } t_cfg_index;

    // Topology codes.
    localparam logic [TOPO_W-1:0] TOPO_SWITCH    = 3'd0;
    localparam logic [TOPO_W-1:0] TOPO_RING      = 3'd1;
    localparam logic [TOPO_W-1:0] TOPO_MESH2D    = 3'd2;
    localparam logic [TOPO_W-1:0] TOPO_TORUS2D   = 3'd3;
    localparam logic [TOPO_W-1:0] TOPO_MESH_ND   = 3'd4;
    localparam logic [TOPO_W-1:0] TOPO_TORUS_ND  = 3'd5;
    localparam logic [TOPO_W-1:0] TOPO_IRREGULAR = 3'd6;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_NODE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_PORT = 2'd2;

    // Link kinds.
    localparam logic [KIND_W-1:0] LK_ROUTER = 2'd0;
    localparam logic [KIND_W-1:0] LK_IFACE  = 2'd1;
    localparam logic [KIND_W-1:0] LK_CLOSED = 2'd2;
    localparam logic [KIND_W-1:0] LK_SELF   = 2'd3;

    // Reset values of the registers.
    localparam logic [TOPO_W-1:0] RST_TOPOLOGY   = TOPO_MESH2D;
    localparam logic [DIMS_W-1:0] RST_DIMENSIONS = 2'd2;
    localparam logic [SIZE_W-1:0] RST_SIZE_AXIS0 = 7'd4;
    localparam logic [SIZE_W-1:0] RST_SIZE_AXIS1 = 7'd4;
    localparam logic [SIZE_W-1:0] RST_SIZE_AXIS2 = 7'd1;
    localparam logic [PCNT_W-1:0] RST_PORT_COUNT = 5'd5;

endpackage

// ===== rtl/core/nhd_div.sv =====
// Pipelined restoring divider for two dividends sharing one divisor, with a sideband.
module nhd_div #(
    parameter int NW  = 18,
    parameter int DW  = 7,
    parameter int BPS = 3,
    parameter int SW  = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [NW-1:0] i_num_a,
    input  logic [NW-1:0] i_num_b,
    input  logic [DW-1:0] i_den,
    input  logic [SW-1:0] i_side,
    output logic          o_valid,
    output logic [NW-1:0] o_quo_a,
    output logic [NW-1:0] o_quo_b,
    output logic [DW-1:0] o_rem_a,
    output logic [DW-1:0] o_rem_b,
    output logic [SW-1:0] o_side
);

    localparam int NS  = (NW + BPS - 1) / BPS;
    localparam int ACW = DW + NW;

    logic           r_valid [NS];
    logic [ACW-1:0] r_acc_a [NS];
    logic [ACW-1:0] r_acc_b [NS];
    logic [SW-1:0]  r_side  [NS];
    logic [ACW-1:0] w_seed_a [NS];
    logic [ACW-1:0] w_seed_b [NS];
    logic [ACW-1:0] n_acc_a [NS];
    logic [ACW-1:0] n_acc_b [NS];

    // One quotient bit: shift the next dividend bit into the remainder and subtract if it fits.
    function automatic logic [ACW-1:0] div_step(input logic [ACW-1:0] acc,
                                                input logic [DW-1:0] den);
        logic [DW:0]   trial;
        logic [DW-1:0] rem;
        logic          qbit;
        trial = {acc[ACW-1 -: DW], acc[NW-1]};
        if (trial >= {1'b0, den}) begin
            rem  = DW'(trial - {1'b0, den});
            qbit = 1'b1;
        end else begin
            rem  = trial[DW-1:0];
            qbit = 1'b0;
        end
        return {rem, acc[NW-2:0], qbit};
    endfunction

    genvar k;
    generate
        for (k = 0; k < NS; k++) begin : g_stage
            // Each stage starts from the previous stage's partial result.
            if (k == 0) begin : g_first
                assign w_seed_a[k] = {{DW{1'b0}}, i_num_a};
                assign w_seed_b[k] = {{DW{1'b0}}, i_num_b};
            end else begin : g_next
                assign w_seed_a[k] = r_acc_a[k-1];
                assign w_seed_b[k] = r_acc_b[k-1];
            end

            // BPS quotient bits per stage; bits beyond the dividend are skipped.
            always_comb begin
                n_acc_a[k] = w_seed_a[k];
                n_acc_b[k] = w_seed_b[k];
                for (int j = 0; j < BPS; j++) begin
                    if (k * BPS + j < NW) begin
                        n_acc_a[k] = div_step(n_acc_a[k], i_den);
                        n_acc_b[k] = div_step(n_acc_b[k], i_den);
                    end
                end
            end

            // Stage valid bit.
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_valid[k] <= 1'b0;
                end else if (i_en) begin
                    r_valid[k] <= (k == 0) ? i_valid : r_valid[(k == 0) ? 0 : k - 1];
                end
            end

            // Stage payload.
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_acc_a[k] <= n_acc_a[k];
                    r_acc_b[k] <= n_acc_b[k];
                    r_side[k]  <= (k == 0) ? i_side : r_side[(k == 0) ? 0 : k - 1];
                end
            end
        end
    endgenerate

    assign o_valid = r_valid[NS-1];
    assign o_quo_a = r_acc_a[NS-1][NW-1:0];
    assign o_quo_b = r_acc_b[NS-1][NW-1:0];
    assign o_rem_a = r_acc_a[NS-1][ACW-1 -: DW];
    assign o_rem_b = r_acc_b[NS-1][ACW-1 -: DW];
    assign o_side  = r_side[NS-1];

endmodule

// ===== rtl/core/noc_neighbor_and_hop_distance.sv =====
// Top level of the network-on-chip neighbour and hop-distance query pipeline.
//
// One query transaction is accepted in every cycle in which o_stall is low, and each gives exactly
// one result, in order: the node numbers are split into coordinates by three chained dividers of
// six stages each (ceil(18 / 3) stages, three quotient bits per stage), followed by one stage
// that classifies the port and takes the coordinate differences and one output stage that forms
// the attached node and the hop sum. A stall on the result side while a result waits holds the
// whole pipeline, and the input stall then follows it in the same cycle. Configuration writes
// take effect in the cycle after the write and every stage reads them, so transactions already in
// flight may see them too; the derived router count and axis strides are registered from them.
module noc_neighbor_and_hop_distance
    import nhd_pkg::*;
#(
    parameter int MAX_DIMENSIONS = DEF_MAX_DIMENSIONS,
    parameter int MAX_AXIS_SIZE  = DEF_MAX_AXIS_SIZE,
    parameter int MAX_PORTS      = DEF_MAX_PORTS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [CMD_W-1:0]      i_command,
    input  logic [NODE_W-1:0]     i_node,
    input  logic [PORT_W-1:0]     i_port_index,
    input  logic [NODE_W-1:0]     i_other_node,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [STATUS_W-1:0]   o_status,
    output logic [KIND_W-1:0]     o_link_kind,
    output logic [NODE_W-1:0]     o_neighbor_node,
    output logic [PORT_W-1:0]     o_neighbor_port,
    output logic [HOP_W-1:0]      o_hop_distance
);

    localparam int SZW   = $clog2(MAX_AXIS_SIZE + 1);
    localparam int AW    = $clog2(MAX_AXIS_SIZE);
    localparam int CW    = 3 * SZW;
    localparam int PCW   = $clog2(MAX_PORTS + 1);
    localparam int CMPW  = (CW > NODE_W) ? CW : NODE_W;
    localparam int PCMPW = (PCW > PORT_W) ? PCW : PORT_W;
    localparam int SWW   = NODE_W + PCW;
    localparam int BPS   = 3;
    localparam int SW0   = CMD_W + PORT_W + 2 * NODE_W;
    localparam int SW1   = SW0 + 2 * AW;
    localparam int SW2   = SW1 + 2 * AW;

    typedef enum logic [2:0] {
        ACT_ZERO,
        ACT_SWITCH,
        ACT_IFACE,
        ACT_SELF,
        ACT_CLOSED,
        ACT_ADD,
        ACT_SUB
    } t_act;

    // Configuration registers.
    logic [TOPO_W-1:0] r_topology;
    logic [DIMS_W-1:0] r_dimensions;
    logic [SIZE_W-1:0] r_size [3];
    logic [PCNT_W-1:0] r_port_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_topology   <= RST_TOPOLOGY;
            r_dimensions <= RST_DIMENSIONS;
            r_size[0]    <= RST_SIZE_AXIS0;
            r_size[1]    <= RST_SIZE_AXIS1;
            r_size[2]    <= RST_SIZE_AXIS2;
            r_port_count <= RST_PORT_COUNT;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_TOPOLOGY:   r_topology   <= i_cfg_data[TOPO_W-1:0];
                CFG_DIMENSIONS: r_dimensions <= i_cfg_data[DIMS_W-1:0];
                CFG_SIZE_AXIS0: r_size[0]    <= i_cfg_data[SIZE_W-1:0];
                CFG_SIZE_AXIS1: r_size[1]    <= i_cfg_data[SIZE_W-1:0];
                CFG_SIZE_AXIS2: r_size[2]    <= i_cfg_data[SIZE_W-1:0];
                CFG_PORT_COUNT: r_port_count <= i_cfg_data[PCNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Effective axis sizes: zero counts as one and large values saturate.
    function automatic logic [SZW-1:0] sat_size(input logic [SIZE_W-1:0] s);
        if (s == '0) begin
            return SZW'(1);
        end else if (int'(s) > MAX_AXIS_SIZE) begin
            return SZW'(MAX_AXIS_SIZE);
        end else begin
            return SZW'(s);
        end
    endfunction

    logic [SZW-1:0]    w_size [3];
    logic [DIMS_W-1:0] w_dims;
    logic [PCW-1:0]    w_pc;

    assign w_size[0] = sat_size(r_size[0]);
    assign w_size[1] = sat_size(r_size[1]);
    assign w_size[2] = sat_size(r_size[2]);

    // Axes in use: ring and switch have one, the two-dimensional kinds two, the others the dimensions
    always_comb begin
        if (r_topology == TOPO_SWITCH || r_topology == TOPO_RING) begin
            w_dims = DIMS_W'(1);
        end else if (r_topology == TOPO_MESH2D || r_topology == TOPO_TORUS2D) begin
            w_dims = DIMS_W'(2);
        end else if (r_dimensions == '0) begin
            w_dims = DIMS_W'(1);
        end else begin
            w_dims = r_dimensions;
        end
        if (int'(w_dims) > MAX_DIMENSIONS) begin
            w_dims = DIMS_W'(MAX_DIMENSIONS);
        end
    end

    // Effective port count.
    always_comb begin
        if (r_port_count == '0) begin
            w_pc = PCW'(1);
        end else if (int'(r_port_count) > MAX_PORTS) begin
            w_pc = PCW'(MAX_PORTS);
        end else begin
            w_pc = PCW'(r_port_count);
        end
    end

    // Axis-2 stride, wrap spans and router count, registered from the configuration registers.
    logic [CW-1:0] r_stride2;
    logic [CW-1:0] r_span1;
    logic [CW-1:0] r_span2;
    logic [CW-1:0] r_count;

    always_ff @(posedge i_clk) begin
        r_stride2 <= CW'(w_size[0]) * CW'(w_size[1]);
        r_span1   <= CW'(w_size[1] - SZW'(1)) * CW'(w_size[0]);
        r_span2   <= CW'(w_size[2] - SZW'(1)) * r_stride2;
        case (w_dims)
            2'd1:    r_count <= CW'(w_size[0]);
            2'd2:    r_count <= r_stride2;
            default: r_count <= r_span2 + r_stride2;
        endcase
    end

    // The whole pipeline advances unless a result is held by the receiver.
    logic r_out_valid;
    logic w_en;

    assign w_en    = !(r_out_valid && i_stall);
    assign o_stall = !w_en;
    assign o_valid = r_out_valid;

    // Coordinate split: three chained dividers by the axis sizes.
    logic              w_d0_valid, w_d1_valid, w_d2_valid;
    logic [NODE_W-1:0] w_q0_a, w_q0_b, w_q1_a, w_q1_b;
    logic [SZW-1:0]    w_r0_a, w_r0_b, w_r1_a, w_r1_b, w_r2_a, w_r2_b;
    logic [SW0-1:0]    w_side0;
    logic [SW1-1:0]    w_side1;
    logic [SW2-1:0]    w_side2;

    nhd_div #(.NW(NODE_W), .DW(SZW), .BPS(BPS), .SW(SW0)) u_div0 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_valid),
        .i_num_a (i_node),
        .i_num_b (i_other_node),
        .i_den   (w_size[0]),
        .i_side  ({i_command, i_port_index, i_node, i_other_node}),
        .o_valid (w_d0_valid),
        .o_quo_a (w_q0_a),
        .o_quo_b (w_q0_b),
        .o_rem_a (w_r0_a),
        .o_rem_b (w_r0_b),
        .o_side  (w_side0)
    );

    nhd_div #(.NW(NODE_W), .DW(SZW), .BPS(BPS), .SW(SW1)) u_div1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_d0_valid),
        .i_num_a (w_q0_a),
        .i_num_b (w_q0_b),
        .i_den   (w_size[1]),
        .i_side  ({w_side0, w_r0_a[AW-1:0], w_r0_b[AW-1:0]}),
        .o_valid (w_d1_valid),
        .o_quo_a (w_q1_a),
        .o_quo_b (w_q1_b),
        .o_rem_a (w_r1_a),
        .o_rem_b (w_r1_b),
        .o_side  (w_side1)
    );

    nhd_div #(.NW(NODE_W), .DW(SZW), .BPS(BPS), .SW(SW2)) u_div2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_d1_valid),
        .i_num_a (w_q1_a),
        .i_num_b (w_q1_b),
        .i_den   (w_size[2]),
        .i_side  ({w_side1, w_r1_a[AW-1:0], w_r1_b[AW-1:0]}),
        .o_valid (w_d2_valid),
        .o_quo_a (),
        .o_quo_b (),
        .o_rem_a (w_r2_a),
        .o_rem_b (w_r2_b),
        .o_side  (w_side2)
    );

    // Unpack the sideband; axes beyond those in use read as zero.
    logic [CMD_W-1:0]  w_cmd;
    logic [PORT_W-1:0] w_port;
    logic [NODE_W-1:0] w_node;
    logic [NODE_W-1:0] w_other;
    logic [AW-1:0]     w_c0_a, w_c0_b, w_c1_a, w_c1_b;
    logic [AW-1:0]     w_ca [3];
    logic [AW-1:0]     w_cb [3];

    assign {w_cmd, w_port, w_node, w_other, w_c0_a, w_c0_b, w_c1_a, w_c1_b} = w_side2;
    assign w_ca[0] = w_c0_a;
    assign w_cb[0] = w_c0_b;
    assign w_ca[1] = (w_dims >= 2'd2) ? w_c1_a : '0;
    assign w_cb[1] = (w_dims >= 2'd2) ? w_c1_b : '0;
    assign w_ca[2] = (w_dims == 2'd3) ? w_r2_a[AW-1:0] : '0;
    assign w_cb[2] = (w_dims == 2'd3) ? w_r2_b[AW-1:0] : '0;

    // Port to axis: the pair number modulo the axis count, counted from the top axis.
    logic [2:0]        w_pair;
    logic [1:0]        w_pair_mod;
    logic [1:0]        w_axis;
    logic [AW-1:0]     w_coord;
    logic [AW-1:0]     w_last;
    logic [CW-1:0]     w_stride;
    logic [CW-1:0]     w_span;
    logic              w_wraps;
    logic              w_bad_node;
    logic              w_bad_port;

    assign w_pair = 3'((w_port - PORT_W'(1)) >> 1);

    always_comb begin
        case (w_dims)
            2'd2:    w_pair_mod = {1'b0, w_pair[0]};
            2'd3: begin
                if (w_pair inside {3'd0, 3'd3, 3'd6}) begin
                    w_pair_mod = 2'd0;
                end else if (w_pair inside {3'd1, 3'd4, 3'd7}) begin
                    w_pair_mod = 2'd1;
                end else begin
                    w_pair_mod = 2'd2;
                end
            end
            default: w_pair_mod = 2'd0;
        endcase
    end

    assign w_axis = 2'(w_dims - 2'd1 - w_pair_mod);

    always_comb begin
        case (w_axis)
            2'd0: begin
                w_coord  = w_ca[0];
                w_last   = AW'(w_size[0] - SZW'(1));
                w_stride = CW'(1);
                w_span   = CW'(w_size[0] - SZW'(1));
            end
            2'd1: begin
                w_coord  = w_ca[1];
                w_last   = AW'(w_size[1] - SZW'(1));
                w_stride = CW'(w_size[0]);
                w_span   = r_span1;
            end
            default: begin
                w_coord  = w_ca[2];
                w_last   = AW'(w_size[2] - SZW'(1));
                w_stride = r_stride2;
                w_span   = r_span2;
            end
        endcase
    end

    assign w_wraps = (r_topology == TOPO_RING) || (r_topology == TOPO_TORUS2D) ||
                     (r_topology == TOPO_TORUS_ND);
    assign w_bad_node = (CMPW'(w_node) >= CMPW'(r_count)) ||
                        (w_cmd == 1'b1 && CMPW'(w_other) >= CMPW'(r_count));
    assign w_bad_port = PCMPW'(w_port) >= PCMPW'(w_pc);

    // Classification of the query into an action on the node number.
    logic [STATUS_W-1:0] n_p1_status;
    t_act                n_p1_act;
    logic [CW-1:0]       n_p1_offset;
    logic [PORT_W-1:0]   n_p1_nport;

    always_comb begin
        n_p1_status = ST_OK;
        n_p1_act    = ACT_ZERO;
        n_p1_offset = '0;
        n_p1_nport  = '0;
        if (w_bad_node) begin
            n_p1_status = ST_BAD_NODE;
        end else if (w_cmd == 1'b1) begin
            n_p1_act = ACT_ZERO;
        end else if (w_bad_port) begin
            n_p1_status = ST_BAD_PORT;
        end else if (r_topology == TOPO_SWITCH) begin
            n_p1_act = ACT_SWITCH;
        end else if (w_port == '0) begin
            n_p1_act = ACT_IFACE;
        end else if (r_topology >= TOPO_IRREGULAR) begin
            n_p1_act   = ACT_SELF;
            n_p1_nport = w_port;
        end else if (w_port[0]) begin
            // Down port: step back, or wrap to the far end on a torus or ring.
            if (w_coord != '0) begin
                n_p1_act    = ACT_SUB;
                n_p1_offset = w_stride;
                n_p1_nport  = w_port + PORT_W'(1);
            end else if (w_wraps) begin
                n_p1_act    = ACT_ADD;
                n_p1_offset = w_span;
                n_p1_nport  = w_port + PORT_W'(1);
            end else begin
                n_p1_act = ACT_CLOSED;
            end
        end else begin
            // Up port: step forward, or wrap to coordinate zero.
            if (w_coord < w_last) begin
                n_p1_act    = ACT_ADD;
                n_p1_offset = w_stride;
                n_p1_nport  = w_port - PORT_W'(1);
            end else if (w_wraps) begin
                n_p1_act    = ACT_SUB;
                n_p1_offset = w_span;
                n_p1_nport  = w_port - PORT_W'(1);
            end else begin
                n_p1_act = ACT_CLOSED;
            end
        end
    end

    // Classification stage registers.
    logic                r_p1_valid;
    logic [STATUS_W-1:0] r_p1_status;
    t_act                r_p1_act;
    logic [CW-1:0]       r_p1_offset;
    logic [PORT_W-1:0]   r_p1_nport;
    logic [PORT_W-1:0]   r_p1_port;
    logic [NODE_W-1:0]   r_p1_node;
    logic                r_p1_dist;
    logic [AW-1:0]       r_p1_diff [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid <= 1'b0;
        end else if (w_en) begin
            r_p1_valid <= w_d2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p1_status <= n_p1_status;
            r_p1_act    <= n_p1_act;
            r_p1_offset <= n_p1_offset;
            r_p1_nport  <= n_p1_nport;
            r_p1_port   <= w_port;
            r_p1_node   <= w_node;
            r_p1_dist   <= (w_cmd == 1'b1) && !w_bad_node;
            for (int a = 0; a < 3; a++) begin
                r_p1_diff[a] <= (w_ca[a] > w_cb[a]) ? (w_ca[a] - w_cb[a]) : (w_cb[a] - w_ca[a]);
            end
        end
    end

    // Result fields from the action.
    logic [KIND_W-1:0] n_out_kind;
    logic [NODE_W-1:0] n_out_node;
    logic [AW+1:0]     w_hop_sum;

    assign w_hop_sum = (AW + 2)'(r_p1_diff[0]) + (AW + 2)'(r_p1_diff[1]) +
                       (AW + 2)'(r_p1_diff[2]);

    always_comb begin
        case (r_p1_act)
            ACT_SWITCH: begin
                n_out_kind = LK_IFACE;
                n_out_node = NODE_W'(SWW'(r_p1_node) * SWW'(w_pc) + SWW'(r_p1_port));
            end
            ACT_IFACE: begin
                n_out_kind = LK_IFACE;
                n_out_node = r_p1_node;
            end
            ACT_SELF: begin
                n_out_kind = LK_SELF;
                n_out_node = r_p1_node;
            end
            ACT_CLOSED: begin
                n_out_kind = LK_CLOSED;
                n_out_node = '0;
            end
            ACT_ADD: begin
                n_out_kind = LK_ROUTER;
                n_out_node = NODE_W'((CMPW + 1)'(r_p1_node) + (CMPW + 1)'(r_p1_offset));
            end
            ACT_SUB: begin
                n_out_kind = LK_ROUTER;
                n_out_node = NODE_W'((CMPW + 1)'(r_p1_node) - (CMPW + 1)'(r_p1_offset));
            end
            default: begin
                n_out_kind = LK_ROUTER;
                n_out_node = '0;
            end
        endcase
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= r_p1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            o_status        <= r_p1_status;
            o_link_kind     <= n_out_kind;
            o_neighbor_node <= n_out_node;
            o_neighbor_port <= r_p1_nport;
            o_hop_distance  <= r_p1_dist ? HOP_W'(w_hop_sum) : '0;
        end
    end

    // An error result carries no other information.
    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_OK) |->
        (o_link_kind == LK_ROUTER && o_neighbor_node == '0 &&
         o_neighbor_port == '0 && o_hop_distance == '0))
        else $error("error result with non-zero fields");

    // A closed edge names no node and no port.
    a_closed_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_link_kind == LK_CLOSED) |->
        (o_neighbor_node == '0 && o_neighbor_port == '0 && o_hop_distance == '0))
        else $error("closed edge with non-zero neighbour");

    // The input is held back only while a result waits.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without a waiting result");

    // A held pipeline keeps its classification stage.
    a_hold_p1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_stall && r_p1_valid) |=> r_p1_valid)
        else $error("classification stage lost during stall");

endmodule
